>>> hdl/double_ended_queue_defines.svh
// ----------------------------------------------------------------------------
// double_ended_queue_defines : assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define DEQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// Next-cycle implication.
`define DEQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

>>> hdl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Operation and status codes and the control bundle of the deque.
// ----------------------------------------------------------------------------
package deq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // memory access and result status for one operation
  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
    status_t status;
  } req_t;

  localparam int OUT_WORD_BITS  = 32;
  localparam int OUT_COUNT_BITS = 15;

endpackage

>>> hdl/deq_mem.sv
// ----------------------------------------------------------------------------
// deq_mem
// Single-port word store with a registered read.
// ----------------------------------------------------------------------------
module deq_mem #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic             rd_en,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    // read data holds until the next read
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/deq_ptr.sv
// ----------------------------------------------------------------------------
// deq_ptr
// Head, tail and fill count of the circular buffer; decodes each operation
// into a memory access and a status.
// ----------------------------------------------------------------------------
module deq_ptr #(
  parameter int DEPTH = 16384,
  localparam int AW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [2:0]          kind,
  output deq_pkg::req_t       req,
  output logic [AW-1:0]       addr,
  output logic [CW-1:0]       count_nxt
);

  import deq_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic [CW-1:0] cnt_r;
  logic          is_full, is_empty;
  req_t          req_c;

  assign head_inc = (head_r == LAST) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? LAST : head_r - 1'b1;
  assign tail_inc = (tail_r == LAST) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? LAST : tail_r - 1'b1;
  assign is_full  = (cnt_r == FULL);
  assign is_empty = (cnt_r == '0);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = cnt_r;
    addr      = head_r;
    req_c     = '{wr_en: 1'b0, rd_en: 1'b0, status: ST_OK};
    unique case (kind)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          req_c.status = ST_FULL;
        end else begin
          addr        = head_dec;
          head_nxt    = head_dec;
          count_nxt   = cnt_r + 1'b1;
          req_c.wr_en = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          req_c.status = ST_FULL;
        end else begin
          addr        = tail_r;
          tail_nxt    = tail_inc;
          count_nxt   = cnt_r + 1'b1;
          req_c.wr_en = 1'b1;
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (is_empty) begin
          req_c.status = ST_EMPTY;
        end else begin
          addr        = head_r;
          req_c.rd_en = 1'b1;
          if (kind == OP_POP_FRONT) begin
            head_nxt  = head_inc;
            count_nxt = cnt_r - 1'b1;
          end
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        if (is_empty) begin
          req_c.status = ST_EMPTY;
        end else begin
          addr        = tail_dec;
          req_c.rd_en = 1'b1;
          if (kind == OP_POP_BACK) begin
            tail_nxt  = tail_dec;
            count_nxt = cnt_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign req = '{wr_en:  req_c.wr_en & accept,
                 rd_en:  req_c.rd_en & accept,
                 status: req_c.status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else if (accept) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= count_nxt;
    end
  end

endmodule

>>> hdl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Deque of signed words in a circular buffer held in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel  | ports                                  | direction
//  ---------+----------------------------------------+----------
//  in       | in_valid/in_ready, in_kind, in_value   | input
//  out      | out_valid/out_ready, out_read_value,   | output
//           | out_status, out_count, out_is_empty    |
//
//  One operation per cycle while in_ready is high.
//  The memory read occupies the cycle after transfer; pointers update at
//  the transfer edge, so a following operation sees them at once.
//  A result stage and an output register decouple the two sides; input
//  stalls only when both are full and out_ready is low.
//  Synchronous active-low reset clears pointers, count and valid flags.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH     = 16384,
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_kind,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_read_value,
  output logic [1:0]          out_status,
  output logic [14:0]         out_count,
  output logic                out_is_empty
);

  import deq_pkg::*;

  `include "double_ended_queue_defines.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  req_t                        req;
  logic [AW-1:0]               addr;
  logic [CW-1:0]               count_nxt;
  logic [WORD_BITS-1:0]        wdata;
  logic [WORD_BITS-1:0]        rdata;
  logic signed [WORD_BITS-1:0] rdata_s;
  logic                        accept, s1_adv;

  // result stage (waits on memory read data)
  logic                        s1_valid_r, s1_valid_nxt;
  logic                        s1_rd_r;
  status_t                     s1_status_r;
  logic [CW-1:0]               s1_count_r;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic signed [31:0]          out_read_value_r;
  status_t                     out_status_r;
  logic [14:0]                 out_count_r;
  logic                        out_is_empty_r;

  assign s1_adv   = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_adv;
  assign accept   = in_valid & in_ready;
  assign wdata    = WORD_BITS'(in_value);
  assign rdata_s  = rdata;

  deq_ptr #(.DEPTH(DEPTH)) u_ptr (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .kind      (in_kind),
    .req       (req),
    .addr      (addr),
    .count_nxt (count_nxt)
  );

  deq_mem #(.DEPTH(DEPTH), .WIDTH(WORD_BITS)) u_mem (
    .clk   (clk),
    .wr_en (req.wr_en),
    .rd_en (req.rd_en),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign s1_valid_nxt  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd_r     <= req.rd_en;
      s1_status_r <= req.status;
      s1_count_r  <= count_nxt;
    end
    if (s1_adv) begin
      // sign-extend the stored word to the port width
      out_read_value_r <= s1_rd_r ? OUT_WORD_BITS'(rdata_s) : '0;
      out_status_r     <= s1_status_r;
      out_count_r      <= OUT_COUNT_BITS'(s1_count_r);
      out_is_empty_r   <= (s1_count_r == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;
  assign out_is_empty   = out_is_empty_r;

  `DEQ_ASSERT_NOW(a_full_count, s1_valid_r && s1_status_r == ST_FULL, s1_count_r == CW'(DEPTH))
  `DEQ_ASSERT_NOW(a_empty_noread, s1_valid_r && s1_status_r == ST_EMPTY, !s1_rd_r && s1_count_r == '0)
  `DEQ_ASSERT_NOW(a_stall_cause, !in_ready, s1_valid_r && out_valid_r && !out_ready)
  `DEQ_ASSERT_NEXT(a_stage_hold, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_count_r))

endmodule

>>> tb/double_ended_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_test : deque regression
// Drives push, pop and peek operations on both ends through the valid/ready
// input channel, with random gaps on the sender and random stalls on the
// receiver. A circular-buffer shadow of the deque predicts every result, and
// each result transfer is checked field by field against the oldest expected
// result. Directed rows (some with fixed results) first, then two random rounds.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
  import deq_pkg::*;

  localparam int DEPTH_Q = 16384;
  localparam bit [2:0] KIND_UNUSED_6 = 3'd6;
  localparam bit [2:0] KIND_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic signed [OUT_WORD_BITS-1:0] read_value;
    status_t                         status;
    logic [OUT_COUNT_BITS-1:0]       count;
    logic                            is_empty;
  } deq_result_t;

  typedef struct {
    bit [2:0]    kind;
    logic [31:0] value;
    bit          typed;
    deq_result_t want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_kind = 3'd0;
  logic signed [31:0] in_value = 32'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_read_value;
  logic [1:0]         out_status;
  logic [14:0]        out_count;
  logic               out_is_empty;

  // shadow deque
  logic [31:0] shadow_mem [DEPTH_Q];
  int          shadow_head = 0;
  int          shadow_tail = 0;
  int          shadow_fill = 0;

  deq_result_t pending_results [$];
  stim_row_t   stim_rows [$];
  int          err_count = 0;
  bit          tx_steady = 1'b0;

  double_ended_queue #(
    .DEPTH     (DEPTH_Q),
    .WORD_BITS (OUT_WORD_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_is_empty   (out_is_empty)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(200_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function void predict_deque(input bit [2:0] kind, input logic [31:0] word,
                              output deq_result_t res);
    int back_idx;
    res = '0;
    res.status = ST_OK;
    case (kind)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_fill >= DEPTH_Q) begin
          res.status = ST_FULL;
        end else if (kind == OP_PUSH_FRONT) begin
          shadow_head = (shadow_head == 0) ? DEPTH_Q - 1 : shadow_head - 1;
          shadow_mem[shadow_head] = word;
          shadow_fill++;
        end else begin
          shadow_mem[shadow_tail] = word;
          shadow_tail = (shadow_tail == DEPTH_Q - 1) ? 0 : shadow_tail + 1;
          shadow_fill++;
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.read_value = shadow_mem[shadow_head];
          if (kind == OP_POP_FRONT) begin
            shadow_head = (shadow_head == DEPTH_Q - 1) ? 0 : shadow_head + 1;
            shadow_fill--;
          end
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          back_idx = (shadow_tail == 0) ? DEPTH_Q - 1 : shadow_tail - 1;
          res.read_value = shadow_mem[back_idx];
          if (kind == OP_POP_BACK) begin
            shadow_tail = back_idx;
            shadow_fill--;
          end
        end
      end
      default: ;  // unused kinds leave the deque alone
    endcase
    res.count = OUT_COUNT_BITS'(shadow_fill);
    res.is_empty = (shadow_fill == 0);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h7fff_ffff;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic bit [2:0] pick_op(input int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return $urandom_range(0, 1) ? KIND_UNUSED_7 : KIND_UNUSED_6;
    r = $urandom_range(0, 99);
    if (r < push_pct) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (r < push_pct + (100 - push_pct) * 3 / 5)
      return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    return $urandom_range(0, 1) ? OP_PEEK_BACK : OP_PEEK_FRONT;
  endfunction

  function void check_field(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  function void add_row(input stim_row_t row_in);
    stim_rows.insert(stim_rows.size(), row_in);
  endfunction

  // called just after a falling edge; returns just after a falling edge, once its item has been taken
  task automatic send_item(input bit [2:0] kind, input logic [31:0] word,
                           input bit use_want, input deq_result_t want);
    int          gap;
    deq_result_t res;
    gap = tx_steady ? 0 : pick_gap();
    if ($urandom_range(0, 59) == 0) tx_steady = !tx_steady;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= word;
    do @(posedge clk); while (!in_ready);
    predict_deque(kind, word, res);
    pending_results.insert(pending_results.size(), use_want ? want : res);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic run_random(input int n_items);
    int push_pct;
    int i;
    push_pct = 50;
    for (i = 0; i < n_items; i++) begin
      if (i % 100 == 0) push_pct = $urandom_range(30, 70);
      if (i == n_items / 2) wait_drained();
      send_item(pick_op(push_pct), rand_word(), 1'b0, '0);
    end
  endtask

  // receiver: random stalls with stall-free stretches
  initial begin
    int stall;
    bit steady;
    stall = 0;
    steady = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 79) == 0) steady = !steady;
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    deq_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: result transfer with none expected: expected nothing, actual %h",
                 $time, {out_read_value, out_status, out_count, out_is_empty});
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        check_field("read_value", want.read_value, out_read_value);
        check_field("status", want.status, out_status);
        check_field("count", want.count, out_count);
        check_field("is_empty", want.is_empty, out_is_empty);
      end
    end
  end

  initial begin
    stim_row_t row;

    // empty-queue reads, unused kinds, word extremes and reads of just-pushed words
    add_row('{OP_POP_FRONT, 32'h0, 1'b1, '{32'sd0, ST_EMPTY, 15'd0, 1'b1}});
    add_row('{OP_POP_BACK, 32'hffff_ffff, 1'b1,
              '{32'sd0, ST_EMPTY, 15'd0, 1'b1}});
    add_row('{OP_PEEK_FRONT, 32'h0, 1'b1, '{32'sd0, ST_EMPTY, 15'd0, 1'b1}});
    add_row('{OP_PEEK_BACK, 32'h0, 1'b1, '{32'sd0, ST_EMPTY, 15'd0, 1'b1}});
    add_row('{KIND_UNUSED_6, 32'h1234_5678, 1'b1,
              '{32'sd0, ST_OK, 15'd0, 1'b1}});
    add_row('{KIND_UNUSED_7, 32'hffff_ffff, 1'b1,
              '{32'sd0, ST_OK, 15'd0, 1'b1}});
    add_row('{OP_PUSH_FRONT, 32'h7fff_ffff, 1'b1,
              '{32'sd0, ST_OK, 15'd1, 1'b0}});
    add_row('{OP_PUSH_BACK, 32'h8000_0000, 1'b1,
              '{32'sd0, ST_OK, 15'd2, 1'b0}});
    add_row('{OP_PEEK_FRONT, 32'h0, 1'b1,
              '{32'sh7fff_ffff, ST_OK, 15'd2, 1'b0}});
    add_row('{OP_PEEK_BACK, 32'h0, 1'b1,
              '{32'sh8000_0000, ST_OK, 15'd2, 1'b0}});
    add_row('{OP_PUSH_FRONT, 32'hffff_ffff, 1'b0, '0});
    add_row('{OP_PUSH_BACK, 32'h0, 1'b0, '0});
    add_row('{KIND_UNUSED_7, 32'h5555_5555, 1'b0, '0});
    add_row('{OP_POP_FRONT, 32'h0, 1'b1,
              '{32'shffff_ffff, ST_OK, 15'd3, 1'b0}});
    add_row('{OP_POP_BACK, 32'h0, 1'b0, '0});
    add_row('{OP_POP_BACK, 32'h0, 1'b0, '0});
    add_row('{OP_POP_FRONT, 32'h0, 1'b1,
              '{32'sh7fff_ffff, ST_OK, 15'd0, 1'b1}});
    add_row('{OP_POP_FRONT, 32'h0, 1'b0, '0});
    add_row('{OP_PUSH_BACK, 32'haaaa_aaaa, 1'b0, '0});
    add_row('{OP_POP_FRONT, 32'h0, 1'b0, '0});
    add_row('{OP_PUSH_FRONT, 32'h5555_5555, 1'b0, '0});
    add_row('{OP_PEEK_BACK, 32'h0, 1'b0, '0});
    add_row('{OP_POP_BACK, 32'h0, 1'b0, '0});
    add_row('{OP_PEEK_FRONT, 32'h0, 1'b0, '0});

    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      send_item(row.kind, row.value, row.typed, row.want);
    end
    wait_drained();

    run_random(575);
    wait_drained();

    run_random(575);

    wait_drained();
    repeat (20) @(negedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> double_ended_queue.f
+incdir+hdl
hdl/deq_pkg.sv
hdl/deq_mem.sv
hdl/deq_ptr.sv
hdl/double_ended_queue.sv
tb/double_ended_queue_test.sv
